### rtl/indexed_sequence_store_defines.svh
// Assertion macros of the indexed sequence store RTL.
// Each macro expects signals named clk and rst in the including module.
`ifndef INDEXED_SEQUENCE_STORE_DEFINES_SVH
`define INDEXED_SEQUENCE_STORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("indexed_sequence_store: check failed");

// The consequent must hold in the cycle after the antecedent.
`define ISS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("indexed_sequence_store: check failed");

`endif

### rtl/iss_pkg.sv
// Shared constants, types and helpers of the indexed sequence store.
// Used by the interfaces, the cell row and the top level.
`default_nettype none

package iss_pkg;

  localparam int CAPACITY  = 64;
  localparam int DATA_W    = 64;
  localparam int POS_W     = 7;
  localparam int PORT_CNT_W = 7;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int CMP_W     = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_ERASE  = 2'd1,
    OP_READ   = 2'd2,
    OP_WRITE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic              accept;
    logic              apply;
    op_t               op;
    logic [CMP_W-1:0]  pos;
    logic [CMP_W-1:0]  count;
    logic [DATA_W-1:0] data;
  } cell_cmd_t;

  function automatic logic [PORT_CNT_W-1:0] count_to_port(input logic [CNT_W-1:0] c);
    logic [CNT_W+PORT_CNT_W-1:0] w;
    w = {{PORT_CNT_W{1'b0}}, c};
    return w[PORT_CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/iss_if.sv
// Request and response channel interfaces of the indexed sequence store.
// Depends on iss_pkg for the field widths.
`default_nettype none

interface iss_req_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   operation;
  logic [iss_pkg::POS_W-1:0]    position;
  logic signed [iss_pkg::DATA_W-1:0] data_in;

  modport source (output valid, operation, position, data_in, input ready);
  modport sink (input valid, operation, position, data_in, output ready);
endinterface

interface iss_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [iss_pkg::DATA_W-1:0] read_value;
  logic                              found;
  logic [1:0]                        status;
  logic [iss_pkg::PORT_CNT_W-1:0]    element_count;

  modport source (output valid, read_value, found, status, element_count, input ready);
  modport sink (input valid, read_value, found, status, element_count, output ready);
endinterface

`default_nettype wire

### rtl/indexed_sequence_store.sv
// Indexed sequence store: an ordered list of up to CAPACITY signed 64-bit
// elements addressed by position, held in a row of shifting cells.
//
// A request word carries operation, position and data_in. Insert opens a gap
// at the position (a position at or past the end appends), erase closes one,
// read returns the element, write overwrites it. Each request gives exactly
// one response word: read_value, found, status and element_count.
//
// After acceptance the response word passes the staging register and then the output
// register. The cell row shifts every element in the cycle of acceptance, so one
// request per cycle is taken as long as responses are taken.
// A staging register sits between the cell row and the output register; when
// the receiver stalls, both fill and req.ready then drops until a response
// word leaves. Reset empties the list and both registers at once; the cell
// contents are left as they were and are never read past element_count.
// Depends on iss_pkg, iss_if, iss_row and the assertion macro header.
`default_nettype none

`include "indexed_sequence_store_defines.svh"

module indexed_sequence_store (
  input wire logic clk,
  input wire logic rst,
  iss_req_if.sink   req,
  iss_rsp_if.source rsp
);
  import iss_pkg::*;

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  op_t                   op;
  logic [CMP_W-1:0]      pos_x;
  logic [CMP_W-1:0]      cnt_x;
  logic [CMP_W-1:0]      pos_eff;
  logic                  in_range;
  logic                  full;
  logic                  accept;
  logic                  apply;
  logic                  found_next;
  status_t               status_next;
  cell_cmd_t             cmd;
  logic [DATA_W-1:0]     row_value;

  logic                  stage_valid;
  logic                  stage_found;
  status_t               stage_status;
  logic [PORT_CNT_W-1:0] stage_count;

  logic                  out_valid;
  logic                  out_free;
  logic [DATA_W-1:0]     out_value;
  logic                  out_found;
  status_t               out_status;
  logic [PORT_CNT_W-1:0] out_count;

  assign op       = op_t'(req.operation);
  assign pos_x    = CMP_W'(req.position);
  assign cnt_x    = CMP_W'(count);
  assign in_range = pos_x < cnt_x;
  assign full     = (count == CNT_W'(CAPACITY));
  assign out_free = !out_valid || rsp.ready;
  assign req.ready = !stage_valid || out_free;
  assign accept   = req.valid && req.ready;

  always_comb begin
    status_next = ST_OK;
    found_next  = 1'b0;
    apply       = 1'b0;
    pos_eff     = pos_x;
    count_next  = count;
    if (op == OP_INSERT) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        apply      = 1'b1;
        found_next = in_range;
        count_next = count + CNT_W'(1);
        if (!in_range) begin
          pos_eff = cnt_x;
        end
      end
    end else if (!in_range) begin
      status_next = ST_ABSENT;
    end else begin
      apply      = 1'b1;
      found_next = 1'b1;
      if (op == OP_ERASE) begin
        count_next = count - CNT_W'(1);
      end
    end
  end

  assign cmd.accept = accept;
  assign cmd.apply  = accept && apply;
  assign cmd.op     = op;
  assign cmd.pos    = pos_eff;
  assign cmd.count  = cnt_x;
  assign cmd.data   = req.data_in;

  iss_row u_row (
    .clk        (clk),
    .cmd        (cmd),
    .read_value (row_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      stage_valid <= accept || (stage_valid && !out_free);
      if (out_free) begin
        out_valid <= stage_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_found  <= found_next;
      stage_status <= status_next;
      stage_count  <= count_to_port(count_next);
    end
    if (out_free && stage_valid) begin
      out_value  <= row_value;
      out_found  <= stage_found;
      out_status <= stage_status;
      out_count  <= stage_count;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.read_value    = out_value;
  assign rsp.found         = out_found;
  assign rsp.status        = out_status;
  assign rsp.element_count = out_count;

  `ISS_ASSERT_SAME(a_count_bound, 1'b1, count <= CNT_W'(CAPACITY))
  `ISS_ASSERT_NEXT(a_full_refused, accept && op == OP_INSERT && full, stage_status == ST_FULL && $stable(count))
  `ISS_ASSERT_NEXT(a_read_found, accept && op == OP_READ && in_range, stage_found && stage_status == ST_OK)
  `ISS_ASSERT_SAME(a_absent_empty, out_valid && out_status == ST_ABSENT, out_value == '0 && !out_found)

endmodule

`default_nettype wire

### rtl/iss_cell.sv
// One storage cell of the shifting row: holds one element and its read tap.
// Depends on iss_pkg for the command type and widths.
`default_nettype none

module iss_cell (
  input  wire logic                       clk,
  input  wire logic [iss_pkg::IDX_W-1:0]  cell_index,
  input  wire iss_pkg::cell_cmd_t         cmd,
  input  wire logic [iss_pkg::DATA_W-1:0] left_value,
  input  wire logic [iss_pkg::DATA_W-1:0] right_value,
  output logic      [iss_pkg::DATA_W-1:0] value,
  output logic      [iss_pkg::DATA_W-1:0] tap
);
  import iss_pkg::*;

  logic [CMP_W-1:0]  idx;
  logic [CMP_W-1:0]  idx_plus;
  logic              hit;
  logic [DATA_W-1:0] value_next;
  logic [DATA_W-1:0] tap_next;

  assign idx      = CMP_W'(cell_index);
  assign idx_plus = idx + CMP_W'(1);
  assign hit      = (idx == cmd.pos);

  always_comb begin
    value_next = value;
    if (cmd.apply) begin
      case (cmd.op)
        OP_INSERT: begin
          if (hit) begin
            value_next = cmd.data;
          end else if (idx > cmd.pos) begin
            value_next = left_value;
          end
        end
        OP_ERASE: begin
          // Cells from the erased place up to the one before the last element pull from the right.
          if (idx >= cmd.pos && idx_plus < cmd.count) begin
            value_next = right_value;
          end
        end
        OP_WRITE: begin
          if (hit) begin
            value_next = cmd.data;
          end
        end
        default: begin
          value_next = value;
        end
      endcase
    end
  end

  assign tap_next = (cmd.apply && cmd.op == OP_READ && hit) ? value : '0;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      value <= value_next;
      tap   <= tap_next;
    end
  end

endmodule

`default_nettype wire

### rtl/iss_row.sv
// Row of CAPACITY cells chained to their neighbors, plus the OR of their read taps.
// Depends on iss_pkg and iss_cell.
`default_nettype none

module iss_row (
  input  wire logic                       clk,
  input  wire iss_pkg::cell_cmd_t         cmd,
  output logic      [iss_pkg::DATA_W-1:0] read_value
);
  import iss_pkg::*;

  logic [DATA_W-1:0] values [CAPACITY];
  logic [DATA_W-1:0] taps   [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_value;
    logic [DATA_W-1:0] right_value;

    if (i == 0) begin : g_first
      assign left_value = '0;
    end else begin : g_mid_left
      assign left_value = values[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_value = '0;
    end else begin : g_mid_right
      assign right_value = values[i+1];
    end

    iss_cell u_cell (
      .clk         (clk),
      .cell_index  (IDX_W'(i)),
      .cmd         (cmd),
      .left_value  (left_value),
      .right_value (right_value),
      .value       (values[i]),
      .tap         (taps[i])
    );
  end

  // At most one tap is nonzero, so an OR picks the read element.
  always_comb begin
    read_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      read_value = read_value | taps[i];
    end
  end

endmodule

`default_nettype wire

### verif/tb_indexed_sequence_store.sv
// Self-checking testbench for indexed_sequence_store: request words drive a queue-based
// shadow of the sequence, and every response word is checked against it in order.
// Depends on iss_pkg, the iss_req_if and iss_rsp_if interfaces and the store RTL.
`default_nettype none

module tb_indexed_sequence_store;
  timeunit 1ns;
  timeprecision 1ps;

  import iss_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1080;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam logic [63:0] MAX_S64 = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] MIN_S64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

  typedef struct packed {
    logic signed [63:0] value;
    logic               found;
    status_t            status;
    logic [6:0]         count;
  } seq_result_t;

  typedef struct packed {
    op_t         op;
    logic [6:0]  pos;
    logic [63:0] data;
    logic        typed;
    seq_result_t want;
  } stim_row_t;

  // Rows marked typed carry their own expected word; the rest use the shadow sequence.
  localparam int unsigned DIRECTED_ROWS = 23;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{OP_READ,   7'd0,   64'd0,   1'b1, '{64'd0,   1'b0, ST_ABSENT, 7'd0}},
    '{OP_ERASE,  7'd127, 64'd0,   1'b1, '{64'd0,   1'b0, ST_ABSENT, 7'd0}},
    '{OP_WRITE,  7'd0,   64'd5,   1'b1, '{64'd0,   1'b0, ST_ABSENT, 7'd0}},
    '{OP_INSERT, 7'd127, MAX_S64, 1'b1, '{64'd0,   1'b0, ST_OK,     7'd1}},
    '{OP_INSERT, 7'd0,   MIN_S64, 1'b1, '{64'd0,   1'b1, ST_OK,     7'd2}},
    '{OP_READ,   7'd0,   64'd0,   1'b1, '{MIN_S64, 1'b1, ST_OK,     7'd2}},
    '{OP_READ,   7'd1,   64'd0,   1'b1, '{MAX_S64, 1'b1, ST_OK,     7'd2}},
    '{OP_READ,   7'd2,   64'd0,   1'b1, '{64'd0,   1'b0, ST_ABSENT, 7'd2}},
    '{OP_INSERT, 7'd1,   64'h0123_4567_89ab_cdef, 1'b0, '0},
    '{OP_INSERT, 7'd3,   ALL_ONES, 1'b0, '0},
    '{OP_WRITE,  7'd3,   64'd0,   1'b0, '0},
    '{OP_READ,   7'd3,   ALL_ONES, 1'b0, '0},
    '{OP_WRITE,  7'd127, ALL_ONES, 1'b1, '{64'd0,  1'b0, ST_ABSENT, 7'd4}},
    '{OP_ERASE,  7'd1,   64'd0,   1'b0, '0},
    '{OP_READ,   7'd1,   64'd0,   1'b0, '0},
    '{OP_ERASE,  7'd2,   64'd0,   1'b0, '0},
    '{OP_ERASE,  7'd0,   64'd0,   1'b0, '0},
    '{OP_READ,   7'd0,   64'd0,   1'b0, '0},
    '{OP_ERASE,  7'd0,   64'd0,   1'b0, '0},
    '{OP_READ,   7'd0,   64'd0,   1'b1, '{64'd0,   1'b0, ST_ABSENT, 7'd0}},
    '{OP_INSERT, 7'd64,  64'haaaa_aaaa_aaaa_aaaa, 1'b0, '0},
    '{OP_INSERT, 7'd0,   64'h5555_5555_5555_5555, 1'b0, '0},
    '{OP_READ,   7'd127, 64'd0,   1'b1, '{64'd0,   1'b0, ST_ABSENT, 7'd2}}
  };

  logic clk;
  logic rst;

  iss_req_if req_ch ();
  iss_rsp_if rsp_ch ();

  indexed_sequence_store DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  logic signed [63:0] shadow_seq [$];
  seq_result_t        awaited_results [$];
  int unsigned        mismatch_count;
  int unsigned        cycle_count;
  int unsigned        send_mode;
  int unsigned        take_mode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mode 0 waits uniformly, mode 1 never waits, mode 2 waits only now and then.
  function automatic int unsigned draw_wait(input int unsigned mode);
    case (mode)
      0: return $urandom_range(0, 17);
      1: return 0;
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 17) : 0;
    endcase
  endfunction

  function automatic seq_result_t apply_to_sequence(input op_t op, input logic [6:0] pos,
                                                    input logic signed [63:0] data);
    seq_result_t r;
    int unsigned p;
    p = pos;
    r.value  = '0;
    r.found  = 1'b0;
    r.status = ST_OK;
    if (op == OP_INSERT) begin
      if (shadow_seq.size() >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        // An element already at the position moves up; otherwise the value is appended.
        if (p < shadow_seq.size()) r.found = 1'b1;
        else p = shadow_seq.size();
        shadow_seq.insert(p, data);
      end
    end else if (p >= shadow_seq.size()) begin
      r.status = ST_ABSENT;
    end else begin
      r.found = 1'b1;
      case (op)
        OP_ERASE: shadow_seq.delete(p);
        OP_READ:  r.value = shadow_seq[p];
        default:  shadow_seq[p] = data;
      endcase
    end
    r.count = 7'(shadow_seq.size());
    return r;
  endfunction

  task automatic send_word(input op_t op, input logic [6:0] pos, input logic [63:0] data,
                           input logic typed, input seq_result_t typed_want);
    int unsigned gap;
    seq_result_t predicted;
    gap = draw_wait(send_mode);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.position  <= pos;
    req_ch.data_in   <= data;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    predicted = apply_to_sequence(op, pos, data);
    awaited_results.insert(awaited_results.size(), typed ? typed_want : predicted);
  endtask

  function automatic logic [6:0] pick_position(input op_t op);
    int unsigned held;
    held = shadow_seq.size();
    if ($urandom_range(0, 3) == 0) return 7'($urandom_range(0, 127));
    if (op == OP_INSERT) return 7'($urandom_range(0, held));
    if (held == 0) return 7'($urandom_range(0, 127));
    return 7'($urandom_range(0, held - 1));
  endfunction

  function automatic logic [63:0] pick_data();
    case ($urandom_range(0, 7))
      0: return MAX_S64;
      1: return MIN_S64;
      2: return 64'd0;
      3: return ALL_ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Fill phases push the store to its limit so that full inserts occur; drain phases empty it.
  function automatic op_t pick_operation(input int unsigned phase_kind);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (phase_kind)
      0: return (roll < 85) ? OP_INSERT : op_t'($urandom_range(1, 3));
      1: return (roll < 75) ? OP_ERASE : op_t'($urandom_range(0, 3));
      2: return op_t'($urandom_range(0, 3));
      default: begin
        if (roll < 20) return OP_INSERT;
        if (roll < 30) return OP_ERASE;
        return (roll < 65) ? OP_READ : OP_WRITE;
      end
    endcase
  endfunction

  initial begin : stimulus
    int unsigned sent;
    int unsigned phase_len;
    int unsigned phase_kind;
    op_t op;
    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.operation <= OP_INSERT;
    req_ch.position  <= '0;
    req_ch.data_in   <= '0;
    rsp_ch.ready     <= 1'b0;
    mismatch_count = 0;
    send_mode = 0;
    take_mode = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_word(DIRECTED[i].op, DIRECTED[i].pos, DIRECTED[i].data,
                DIRECTED[i].typed, DIRECTED[i].want);
    end

    sent = 0;
    phase_kind = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len  = $urandom_range(60, 140);
      send_mode  = $urandom_range(0, 2);
      take_mode  = $urandom_range(0, 2);
      for (int j = 0; j < phase_len && sent < RANDOM_ITEMS; j++) begin
        op = pick_operation(phase_kind);
        send_word(op, pick_position(op), pick_data(), 1'b0, '0);
        sent++;
      end
      phase_kind = (phase_kind + 1) % 4;
    end
    req_ch.valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : response_check
    int unsigned stall;
    seq_result_t want;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = draw_wait(take_mode);
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      if (awaited_results.size() == 0) begin
        $error("response word arrived with no request outstanding");
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (rsp_ch.read_value !== want.value) begin
          $error("read_value: expected %0d, got %0d", want.value, rsp_ch.read_value);
          mismatch_count++;
        end
        if (rsp_ch.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, rsp_ch.found);
          mismatch_count++;
        end
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          mismatch_count++;
        end
        if (rsp_ch.element_count !== want.count) begin
          $error("element_count: expected %0d, got %0d", want.count, rsp_ch.element_count);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
